// ----- sv/deadline_job_timer_table_macros.svh -----
// Assertion macros for the deadline job timer table
`ifndef DEADLINE_JOB_TIMER_TABLE_MACROS_SVH
`define DEADLINE_JOB_TIMER_TABLE_MACROS_SVH

// same-cycle implication, reset masked
`define DJT_ASSERT_NOW(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// next-cycle implication, reset masked
`define DJT_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ----- sv/djt_pkg.sv -----
// Shared types and constants for the deadline job timer table
`default_nettype none

package djt_pkg;

	localparam int MAX_RESULTS = 16;

	localparam logic [1:0] OP_NEW_TIME = 2'd0;
	localparam logic [1:0] OP_ADD      = 2'd1;
	localparam logic [1:0] OP_REMOVE   = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] now_seconds;
		logic [3:0]  slot_index;
		logic [23:0] job_period;
		logic        repeats;
	} item_t;

	typedef struct packed {
		logic [3:0] fired_slot;
		logic       last_fired;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SWEEP,
		ST_SCAN,
		ST_DECIDE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic capture;
		logic add_write;
		logic remove;
		logic set_time;
		logic walk_start;
		logic walk;
		logic sweep;
		logic take;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic is_add;
		logic is_remove;
		logic is_new;
		logic time_eq;
		logic time_back;
		logic walk_last;
		logic best_found;
		logic count_last;
	} sts_t;

endpackage

`default_nettype wire

// ----- sv/djt_ctrl.sv -----
// Sequencing FSM for the deadline job timer table
`default_nettype none

module djt_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  djt_pkg::sts_t     sts,
	output djt_pkg::cmd_t     cmd
);

	djt_pkg::state_t state_q;
	djt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= djt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			djt_pkg::ST_IDLE: begin
				if (start) state_d = djt_pkg::ST_DISPATCH;
			end
			djt_pkg::ST_DISPATCH: begin
				if (sts.is_new && !sts.time_eq) begin
					state_d = sts.time_back ? djt_pkg::ST_SWEEP : djt_pkg::ST_SCAN;
				end else begin
					state_d = djt_pkg::ST_IDLE;
				end
			end
			djt_pkg::ST_SWEEP: begin
				if (sts.walk_last) state_d = djt_pkg::ST_IDLE;
			end
			djt_pkg::ST_SCAN: begin
				if (sts.walk_last) state_d = djt_pkg::ST_DECIDE;
			end
			djt_pkg::ST_DECIDE: begin
				if (!sts.best_found) begin
					state_d = djt_pkg::ST_IDLE;
				end else if (sts.count_last) begin
					state_d = djt_pkg::ST_FLUSH;
				end else begin
					state_d = djt_pkg::ST_SCAN;
				end
			end
			djt_pkg::ST_FLUSH: begin
				state_d = djt_pkg::ST_IDLE;
			end
			default: begin
				state_d = djt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			djt_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			djt_pkg::ST_DISPATCH: begin
				cmd.add_write  = sts.is_add;
				cmd.remove     = sts.is_remove;
				cmd.set_time   = sts.is_new && !sts.time_eq;
				cmd.walk_start = sts.is_new && !sts.time_eq;
			end
			djt_pkg::ST_SWEEP: begin
				cmd.walk  = 1'b1;
				cmd.sweep = 1'b1;
			end
			djt_pkg::ST_SCAN: begin
				cmd.walk = 1'b1;
			end
			djt_pkg::ST_DECIDE: begin
				cmd.take       = sts.best_found;
				cmd.walk_start = sts.best_found && !sts.count_last;
				cmd.flush      = !sts.best_found;
			end
			djt_pkg::ST_FLUSH: begin
				cmd.flush = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/djt_datapath.sv -----
// Slot store, scan comparator and result register for the deadline job timer table
`default_nettype none

module djt_datapath #(
	parameter int SLOTS       = 16,
	parameter int TIME_BITS   = 32,
	parameter int PERIOD_BITS = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  djt_pkg::item_t     item,
	input  djt_pkg::cmd_t      cmd,
	output djt_pkg::sts_t      sts,
	output djt_pkg::result_t   result,
	output logic               strobe
);

	localparam int IW = $clog2(SLOTS);
	localparam int SW = ((TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS) + 1;
	localparam int CW = $clog2(djt_pkg::MAX_RESULTS);
	localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
	localparam logic [CW-1:0] LAST_CNT  = CW'(djt_pkg::MAX_RESULTS - 1);

	// captured item
	logic [1:0]             op_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [IW-1:0]          idx_q;
	logic                   slot_ok_q;
	logic [PERIOD_BITS-1:0] per_q;
	logic                   rep_q;

	// slot state
	logic [TIME_BITS-1:0]   cur_q;
	logic [SLOTS-1:0]       valid_q;
	logic [SLOTS-1:0]       repeats_q;
	logic [SLOTS-1:0]       picked_q;
	logic [TIME_BITS-1:0]   dl_mem [SLOTS];
	logic [PERIOD_BITS-1:0] pd_mem [SLOTS];

	// walk over the slots
	logic [IW-1:0]          ptr_q;
	logic                   walking_q;
	logic                   rd_s1;
	logic [IW-1:0]          idx_s1;
	logic [TIME_BITS-1:0]   dl_s1;
	logic [PERIOD_BITS-1:0] pd_s1;

	// running minimum
	logic                   best_found_q;
	logic [IW-1:0]          best_idx_q;
	logic [TIME_BITS-1:0]   best_dl_q;
	logic [PERIOD_BITS-1:0] best_pd_q;

	// one result held back until we know whether it is the last
	logic                   pend_q;
	logic [IW-1:0]          pend_idx_q;
	logic [CW-1:0]          count_q;

	logic                   strobe_q;
	djt_pkg::result_t       result_q;

	logic                   rd_en;
	logic                   cand;
	logic                   sweep_rearm;
	logic                   sweep_drop;
	logic [PERIOD_BITS-1:0] per_sel;
	logic [SW-1:0]          sum;
	logic [TIME_BITS-1:0]   sat_dl;
	logic                   dl_we;
	logic [IW-1:0]          dl_wa;
	logic                   pd_we;

	assign rd_en = cmd.walk && walking_q;

	assign cand = cmd.walk && !cmd.sweep && rd_s1 && valid_q[idx_s1] && !picked_q[idx_s1]
		&& (dl_s1 <= cur_q);
	assign sweep_rearm = cmd.walk && cmd.sweep && rd_s1 && valid_q[idx_s1] && repeats_q[idx_s1];
	assign sweep_drop  = cmd.walk && cmd.sweep && rd_s1 && valid_q[idx_s1] && !repeats_q[idx_s1];

	// shared saturating deadline adder; cur_q already holds the new time on a rearm
	always_comb begin
		if (cmd.add_write) begin
			per_sel = per_q;
		end else if (cmd.sweep) begin
			per_sel = pd_s1;
		end else begin
			per_sel = best_pd_q;
		end
		sum    = SW'(cur_q) + SW'(per_sel);
		sat_dl = (|sum[SW-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];
	end

	always_comb begin
		dl_we = 1'b0;
		dl_wa = idx_q;
		pd_we = cmd.add_write && slot_ok_q;
		if (cmd.add_write && slot_ok_q) begin
			dl_we = 1'b1;
		end else if (sweep_rearm) begin
			dl_we = 1'b1;
			dl_wa = idx_s1;
		end else if (cmd.take && repeats_q[best_idx_q]) begin
			dl_we = 1'b1;
			dl_wa = best_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (dl_we) dl_mem[dl_wa] <= sat_dl;
		if (rd_en) dl_s1 <= dl_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (pd_we) pd_mem[idx_q] <= per_q;
		if (rd_en) pd_s1 <= pd_mem[ptr_q];
	end

	// item capture and best-slot payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q     <= TIME_BITS'(item.now_seconds);
			idx_q     <= IW'(item.slot_index);
			slot_ok_q <= (32'(item.slot_index) < SLOTS);
			per_q     <= PERIOD_BITS'(item.job_period);
			rep_q     <= item.repeats;
		end
		if (cand && (!best_found_q || (dl_s1 < best_dl_q))) begin
			best_idx_q <= idx_s1;
			best_dl_q  <= dl_s1;
			best_pd_q  <= pd_s1;
		end
		if (cmd.take) pend_idx_q <= best_idx_q;
		result_q.fired_slot <= 4'(pend_idx_q);
		result_q.last_fired <= cmd.flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= djt_pkg::OP_NEW_TIME;
			cur_q        <= '0;
			valid_q      <= '0;
			repeats_q    <= '0;
			picked_q     <= '0;
			ptr_q        <= '0;
			walking_q    <= 1'b0;
			rd_s1        <= 1'b0;
			idx_s1       <= '0;
			best_found_q <= 1'b0;
			pend_q       <= 1'b0;
			count_q      <= '0;
			strobe_q     <= 1'b0;
		end else begin
			if (cmd.capture) op_q <= item.opcode;

			if (cmd.add_write && slot_ok_q) begin
				valid_q[idx_q]   <= 1'b1;
				repeats_q[idx_q] <= rep_q;
			end
			if (cmd.remove && slot_ok_q) begin
				valid_q[idx_q]   <= 1'b0;
				repeats_q[idx_q] <= 1'b0;
			end
			if (sweep_drop) valid_q[idx_s1] <= 1'b0;

			if (cmd.set_time) begin
				cur_q    <= now_q;
				picked_q <= '0;
				pend_q   <= 1'b0;
				count_q  <= '0;
			end

			if (cmd.walk_start) begin
				ptr_q        <= '0;
				walking_q    <= 1'b1;
				best_found_q <= 1'b0;
			end else if (rd_en) begin
				ptr_q <= ptr_q + 1'b1;
				if (ptr_q == LAST_IDX) walking_q <= 1'b0;
			end
			rd_s1  <= rd_en;
			idx_s1 <= ptr_q;

			if (cand) best_found_q <= 1'b1;

			if (cmd.take) begin
				picked_q[best_idx_q] <= 1'b1;
				if (!repeats_q[best_idx_q]) valid_q[best_idx_q] <= 1'b0;
				pend_q  <= 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (cmd.flush) pend_q <= 1'b0;

			// the held result goes out once the next scan or a flush settles its last flag
			strobe_q <= (cmd.take || cmd.flush) && pend_q;
		end
	end

	always_comb begin
		sts            = '0;
		sts.is_add     = (op_q == djt_pkg::OP_ADD);
		sts.is_remove  = (op_q == djt_pkg::OP_REMOVE);
		sts.is_new     = (op_q == djt_pkg::OP_NEW_TIME);
		sts.time_eq    = (now_q == cur_q);
		sts.time_back  = (now_q < cur_q);
		sts.walk_last  = rd_s1 && (idx_s1 == LAST_IDX);
		sts.best_found = best_found_q;
		sts.count_last = (count_q == LAST_CNT);
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ----- sv/deadline_job_timer_table.sv -----
// Deadline job timer table: SLOTS timer slots, each armed by an add beat with a deadline
// of the current time plus its interval (saturating), cleared by a remove beat. A new-time
// beat that moves time forward fires every armed slot whose deadline is at or before the
// new time, one result per slot in ascending deadline order (ties to the lower slot), the
// final one flagged by last_fired; periodic slots rearm at the new time plus their interval
// and one-shot slots clear. Time moving backwards rearms periodic slots, drops one-shot
// slots and fires nothing. A beat is taken when start is high and busy low. Add, remove and
// an unchanged time go back to idle straight from dispatch; a backward step makes one sweep
// over the slots; a forward step makes a scan pass per fired slot (at most 16 fire) and,
// if fewer fire, a final pass that finds none, since every result needs a full pass over
// the slot memory through its single read port, one slot a cycle. Results leave through a
// register, each on the result port for one cycle with strobe high, and cannot be held off
// by the receiver; the last one appears in the same cycle as busy falls.
`default_nettype none

module deadline_job_timer_table #(
	parameter int SLOTS       = 16,
	parameter int TIME_BITS   = 32,
	parameter int PERIOD_BITS = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  djt_pkg::item_t     item,
	output djt_pkg::result_t   result,
	output logic               strobe
);

`include "deadline_job_timer_table_macros.svh"

	djt_pkg::cmd_t cmd;
	djt_pkg::sts_t sts;

	djt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	djt_datapath #(
		.SLOTS       (SLOTS),
		.TIME_BITS   (TIME_BITS),
		.PERIOD_BITS (PERIOD_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.strobe (strobe)
	);

	`DJT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
	`DJT_ASSERT_NOW(a_more_busy, strobe && !result.last_fired, busy, "non-final result while idle")
	`DJT_ASSERT_NEXT(a_last_alone, strobe && result.last_fired, !strobe, "result after final one")

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the deadline job timer table: directed beat table, then random beats
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = 16;
	localparam int PREDICTED    = -1;
	localparam int RANDOM_BEATS = 410;
	// slowest update: 16 slots fired, one full slot pass per result
	localparam int DRAIN_CYCLES = 2 + djt_pkg::MAX_RESULTS * (SLOTS + 2) + 10;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam djt_pkg::result_t NO_FIRE = '0;

	// n_typed of PREDICTED means the predictor supplies the expected results
	typedef struct {
		djt_pkg::item_t   beat;
		int               n_typed;
		djt_pkg::result_t first;
		djt_pkg::result_t second;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	djt_pkg::item_t   item;
	djt_pkg::result_t result;
	logic             strobe;

	always #6 clk = ~clk;

	deadline_job_timer_table #(
		.SLOTS(SLOTS),
		.TIME_BITS(32),
		.PERIOD_BITS(24)
	) dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.item,
		.result,
		.strobe
	);

	// timer table as the bench sees it
	logic        armed [SLOTS];
	logic        rearms [SLOTS];
	logic [23:0] interval [SLOTS];
	logic [31:0] deadline [SLOTS];
	logic [31:0] clock_now;

	djt_pkg::result_t fires_due [$];
	int               fault_count = 0;

	function automatic logic [31:0] sat_sum(input logic [31:0] base, input logic [23:0] span);
		logic [32:0] total;
		total = {1'b0, base} + {9'd0, span};
		return total[32] ? 32'hFFFF_FFFF : total[31:0];
	endfunction

	function automatic djt_pkg::item_t mk_beat(input logic [1:0] op, input logic [31:0] t,
			input logic [3:0] s, input logic [23:0] p, input logic rep);
		return '{opcode: op, now_seconds: t, slot_index: s, job_period: p, repeats: rep};
	endfunction

	function automatic djt_pkg::result_t fired_as(input logic [3:0] s, input logic last);
		return '{fired_slot: s, last_fired: last};
	endfunction

	// applies one beat to the table and lists the slots it fires, in firing order
	function automatic void advance_table(input djt_pkg::item_t b,
			ref djt_pkg::result_t fired [$]);
		logic [31:0] prior;
		logic        taken [SLOTS];
		int          best;
		fired.delete();
		case (b.opcode)
			djt_pkg::OP_ADD: begin
				armed[b.slot_index]    = 1'b1;
				rearms[b.slot_index]   = b.repeats;
				interval[b.slot_index] = b.job_period;
				deadline[b.slot_index] = sat_sum(clock_now, b.job_period);
			end
			djt_pkg::OP_REMOVE: begin
				armed[b.slot_index]  = 1'b0;
				rearms[b.slot_index] = 1'b0;
			end
			djt_pkg::OP_NEW_TIME: begin
				if (b.now_seconds != clock_now) begin
					prior     = clock_now;
					clock_now = b.now_seconds;
					if (prior > clock_now) begin
						// clock stepped back: nothing fires
						for (int i = 0; i < SLOTS; i++) begin
							if (armed[i] && rearms[i])
								deadline[i] = sat_sum(clock_now, interval[i]);
							else
								armed[i] = 1'b0;
						end
					end else begin
						for (int i = 0; i < SLOTS; i++)
							taken[i] = 1'b0;
						while (fired.size() < djt_pkg::MAX_RESULTS) begin
							best = -1;
							for (int i = 0; i < SLOTS; i++) begin
								if (armed[i] && !taken[i] && deadline[i] <= clock_now &&
										(best < 0 || deadline[i] < deadline[best]))
									best = i;
							end
							if (best < 0)
								break;
							taken[best] = 1'b1;
							fired = {fired, fired_as(4'(best), 1'b0)};
						end
						foreach (fired[k]) begin
							if (rearms[fired[k].fired_slot])
								deadline[fired[k].fired_slot] =
									sat_sum(clock_now, interval[fired[k].fired_slot]);
							else
								armed[fired[k].fired_slot] = 1'b0;
							fired[k].last_fired = (k == fired.size() - 1);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_beat(input row_t r);
		djt_pkg::result_t fore [$];
		start <= 1'b1;
		item  <= r.beat;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		advance_table(r.beat, fore);
		if (r.n_typed == PREDICTED) begin
			foreach (fore[k])
				fires_due = {fires_due, fore[k]};
		end else begin
			if (r.n_typed > 0)
				fires_due = {fires_due, r.first};
			if (r.n_typed > 1)
				fires_due = {fires_due, r.second};
		end
	endtask

	task automatic maybe_pause(input bit quiet);
		if (!quiet && $urandom_range(0, 99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
		end
	endtask

	always @(posedge clk) begin : fire_check
		djt_pkg::result_t want;
		if (arst_n && strobe) begin
			if (fires_due.size() == 0) begin
				$error("fired beat with none expected: fired_slot %0d last_fired %0b",
					result.fired_slot, result.last_fired);
				fault_count++;
			end else begin
				want = fires_due.pop_front();
				if (result.fired_slot !== want.fired_slot) begin
					$error("fired_slot: expected %0d, actual %0d",
						want.fired_slot, result.fired_slot);
					fault_count++;
				end
				if (result.last_fired !== want.last_fired) begin
					$error("last_fired: expected %0b, actual %0b",
						want.last_fired, result.last_fired);
					fault_count++;
				end
			end
		end
	end

	initial begin : stimulus
		row_t           plan [20];
		djt_pkg::item_t b;
		int             sent;
		int             roll;
		logic [23:0]    span;
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		clock_now = '0;
		for (int i = 0; i < SLOTS; i++) begin
			armed[i]  = 1'b0;
			rearms[i] = 1'b0;
		end
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'd0, 4'd0, 24'd0, 1'b0), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_ADD, 32'hFFFF_FFFF, 4'd0, 24'd5, 1'b1), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_ADD, 32'd0, 4'd15, 24'hFF_FFFF, 1'b0), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_ADD, 32'd0, 4'd3, 24'd0, 1'b1), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'd5, 4'd0, 24'd0, 1'b0), 2,
				fired_as(4'd3, 1'b0), fired_as(4'd0, 1'b1)},
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'd5, 4'd15, 24'hFF_FFFF, 1'b1), 0,
				NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_REMOVE, 32'd0, 4'd7, 24'd0, 1'b0), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 24'hFF_FFFF, 1'b1), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'd6, 4'd0, 24'd0, 1'b0), 1,
				fired_as(4'd3, 1'b1), NO_FIRE},
			'{mk_beat(djt_pkg::OP_REMOVE, 32'd0, 4'd3, 24'd0, 1'b0), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'hFFFF_FFFF, 4'd0, 24'd0, 1'b0), 2,
				fired_as(4'd0, 1'b0), fired_as(4'd15, 1'b1)},
			// deadline clamps at the top of the time range
			'{mk_beat(djt_pkg::OP_ADD, 32'd0, 4'd8, 24'hFF_FFFF, 1'b0), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'd2, 4'd0, 24'd0, 1'b0), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'd7, 4'd0, 24'd0, 1'b0), 1,
				fired_as(4'd0, 1'b1), NO_FIRE},
			'{mk_beat(djt_pkg::OP_ADD, 32'd0, 4'd0, 24'd1, 1'b0), 0, NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'd8, 4'd0, 24'd0, 1'b0), 1,
				fired_as(4'd0, 1'b1), NO_FIRE},
			'{mk_beat(djt_pkg::OP_ADD, 32'd0, 4'd2, 24'd100, 1'b0), PREDICTED,
				NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_ADD, 32'd0, 4'd1, 24'd100, 1'b1), PREDICTED,
				NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'd200, 4'd0, 24'd0, 1'b0), PREDICTED,
				NO_FIRE, NO_FIRE},
			'{mk_beat(djt_pkg::OP_NEW_TIME, 32'd0, 4'd0, 24'd0, 1'b0), PREDICTED,
				NO_FIRE, NO_FIRE}
		};
		foreach (plan[n]) begin
			send_beat(plan[n]);
			maybe_pause(1'b0);
		end

		sent = 0;
		while (sent < RANDOM_BEATS) begin
			roll = $urandom_range(0, 99);
			b = mk_beat(djt_pkg::OP_ADD, $urandom, 4'($urandom_range(0, 15)),
				24'($urandom_range(0, 24'hFF_FFFF)), 1'($urandom_range(0, 1)));
			if (roll < 4) begin
				b.opcode = OP_UNUSED;
			end else if (roll < 7) begin
				// arm every slot with one interval, then step past it: all sixteen fire unless the clock wraps
				span = 24'($urandom_range(0, 12));
				for (int s = 0; s < SLOTS; s++) begin
					b.slot_index  = 4'(s);
					b.job_period  = span;
					b.repeats     = 1'($urandom_range(0, 1));
					b.now_seconds = $urandom;
					send_beat('{b, PREDICTED, NO_FIRE, NO_FIRE});
					sent++;
					maybe_pause(sent >= 150 && sent < 270);
				end
				b.opcode      = djt_pkg::OP_NEW_TIME;
				b.now_seconds = clock_now + 32'(span) + 32'($urandom_range(1, 3));
			end else if (roll < 52) begin
				roll = $urandom_range(0, 99);
				if (roll < 60)
					b.job_period = 24'($urandom_range(0, 15));
				else if (roll < 85)
					b.job_period = 24'($urandom_range(0, 255));
			end else if (roll < 62) begin
				b.opcode = djt_pkg::OP_REMOVE;
			end else begin
				b.opcode = djt_pkg::OP_NEW_TIME;
				roll = $urandom_range(0, 99);
				if (roll < 70)
					b.now_seconds = clock_now + 32'($urandom_range(1, 20));
				else if (roll < 78)
					b.now_seconds = clock_now;
				else if (roll < 88)
					b.now_seconds = (clock_now == 0) ? 32'd0 : $urandom_range(0, clock_now - 1);
				else if (roll >= 95)
					b.now_seconds = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
			end
			send_beat('{b, PREDICTED, NO_FIRE, NO_FIRE});
			if (b.opcode != OP_UNUSED)
				sent++;
			maybe_pause(sent >= 150 && sent < 270);
		end

		start <= 1'b0;
		while (fires_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fault_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
